### rtl/lkvt_pkg.sv
`default_nettype none
package lkvt_pkg;

    localparam int LKVT_CAPACITY = 16;
    localparam int KEY_W         = 32;
    localparam int VALUE_W       = 32;
    localparam int CMD_W         = 3;
    localparam int STATUS_W      = 2;
    localparam int TOTAL_W       = 5;

    localparam logic [CMD_W-1:0] CMD_INSERT = 3'd0;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_SEARCH = 3'd2;
    localparam logic [CMD_W-1:0] CMD_GET    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_SET    = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_DUP     = 2'd2;
    localparam logic [STATUS_W-1:0] ST_MISSING = 2'd3;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CMP,
        S_SHIFT_RD,
        S_SHIFT_WR,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

### rtl/lkvt_store.sv
`default_nettype none
module lkvt_store #(
    parameter int CAPACITY = lkvt_pkg::LKVT_CAPACITY,
    parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_we,
    input  wire logic [IDX_W-1:0]           i_waddr,
    input  wire logic [lkvt_pkg::KEY_W-1:0]   i_wkey,
    input  wire logic [lkvt_pkg::VALUE_W-1:0] i_wval,
    input  wire logic [IDX_W-1:0]           i_raddr,
    output logic      [lkvt_pkg::KEY_W-1:0]   o_rkey,
    output logic      [lkvt_pkg::VALUE_W-1:0] o_rval
);
    import lkvt_pkg::*;

    logic [KEY_W-1:0]   r_keys [CAPACITY];
    logic [VALUE_W-1:0] r_vals [CAPACITY];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_keys[i_waddr] <= i_wkey;
            r_vals[i_waddr] <= i_wval;
        end
    end

    always_ff @(posedge i_clk) begin
        o_rkey <= r_keys[i_raddr];
        o_rval <= r_vals[i_raddr];
    end

endmodule
`default_nettype wire

### rtl/lkvt_seq.sv
`default_nettype none
module lkvt_seq #(
    parameter int CAPACITY = lkvt_pkg::LKVT_CAPACITY,
    parameter int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1,
    parameter int CNT_W    = $clog2(CAPACITY + 1)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [lkvt_pkg::CMD_W-1:0]     i_command,
    input  wire logic [lkvt_pkg::KEY_W-1:0]     i_key,
    input  wire logic [lkvt_pkg::VALUE_W-1:0]   i_new_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [lkvt_pkg::STATUS_W-1:0]  o_status,
    output logic      [lkvt_pkg::VALUE_W-1:0]   o_found_value,
    output logic      [lkvt_pkg::TOTAL_W-1:0]   o_entry_total,
    output logic                               o_we,
    output logic      [IDX_W-1:0]              o_waddr,
    output logic      [lkvt_pkg::KEY_W-1:0]     o_wkey,
    output logic      [lkvt_pkg::VALUE_W-1:0]   o_wval,
    output logic      [IDX_W-1:0]              o_raddr,
    input  wire logic [lkvt_pkg::KEY_W-1:0]     i_rkey,
    input  wire logic [lkvt_pkg::VALUE_W-1:0]   i_rval
);
    import lkvt_pkg::*;

    t_state               r_state, n_state;
    logic [CMD_W-1:0]     r_cmd, n_cmd;
    logic [KEY_W-1:0]     r_key, n_key;
    logic [VALUE_W-1:0]   r_val, n_val;
    logic [IDX_W-1:0]     r_idx, n_idx;
    logic [CNT_W-1:0]     r_count, n_count;
    logic [STATUS_W-1:0]  r_status, n_status;
    logic [VALUE_W-1:0]   r_found, n_found;
    logic                 r_out_valid, n_out_valid;
    logic [STATUS_W-1:0]  r_out_status, n_out_status;
    logic [VALUE_W-1:0]   r_out_found, n_out_found;
    logic [TOTAL_W-1:0]   r_out_total, n_out_total;

    logic accept;
    logic key_match;
    logic scan_last;
    logic shift_last;
    logic out_free;
    logic [CNT_W-1:0] idx_ext;

    assign accept     = i_in_valid && (r_state == S_IDLE);
    assign idx_ext    = CNT_W'(r_idx);
    // shared comparator
    assign key_match  = (i_rkey == r_key);
    assign scan_last  = ((idx_ext + 1'b1) == r_count);
    assign shift_last = ((idx_ext + CNT_W'(2)) == r_count);
    assign out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    if (i_command > CMD_SET
                        || (i_command == CMD_INSERT && r_count >= CNT_W'(CAPACITY))
                        || r_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_READ;
                    end
                end
            end
            S_READ: n_state = S_CMP;
            S_CMP: begin
                if (key_match) begin
                    if (r_cmd == CMD_REMOVE && !scan_last) begin
                        n_state = S_SHIFT_RD;
                    end else begin
                        n_state = S_DONE;
                    end
                end else if (scan_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_READ;
                end
            end
            S_SHIFT_RD: n_state = S_SHIFT_WR;
            S_SHIFT_WR: begin
                if (shift_last) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_SHIFT_RD;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_cmd        = r_cmd;
        n_key        = r_key;
        n_val        = r_val;
        n_idx        = r_idx;
        n_count      = r_count;
        n_status     = r_status;
        n_found      = r_found;
        n_out_valid  = r_out_valid && !i_out_ready;
        n_out_status = r_out_status;
        n_out_found  = r_out_found;
        n_out_total  = r_out_total;
        o_we         = 1'b0;
        o_waddr      = r_idx;
        o_wkey       = r_key;
        o_wval       = r_val;
        o_raddr      = r_idx;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_cmd    = i_command;
                    n_key    = i_key;
                    n_val    = i_new_value;
                    n_idx    = '0;
                    n_status = ST_OK;
                    n_found  = '0;
                    if (i_command == CMD_INSERT) begin
                        if (r_count >= CNT_W'(CAPACITY)) begin
                            n_status = ST_FULL;
                        end else if (r_count == '0) begin
                            o_we    = 1'b1;
                            o_waddr = '0;
                            o_wkey  = i_key;
                            o_wval  = i_new_value;
                            n_count = CNT_W'(1);
                        end
                    end else if (i_command <= CMD_SET && r_count == '0) begin
                        n_status = ST_MISSING;
                    end
                end
            end
            S_READ: o_raddr = r_idx;
            S_CMP: begin
                if (key_match) begin
                    case (r_cmd)
                        CMD_INSERT: n_status = ST_DUP;
                        CMD_GET:    n_found  = i_rval;
                        CMD_SET:    o_we     = 1'b1;
                        CMD_REMOVE: begin
                            if (scan_last) begin
                                n_count = r_count - 1'b1;
                            end
                        end
                        default: ;
                    endcase
                end else if (scan_last) begin
                    if (r_cmd == CMD_INSERT) begin
                        o_we    = 1'b1;
                        o_waddr = IDX_W'(r_count);
                        n_count = r_count + 1'b1;
                    end else begin
                        n_status = ST_MISSING;
                    end
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_SHIFT_RD: o_raddr = r_idx + 1'b1;
            S_SHIFT_WR: begin
                o_we   = 1'b1;
                o_wkey = i_rkey;
                o_wval = i_rval;
                if (shift_last) begin
                    n_count = r_count - 1'b1;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            S_DONE: begin
                if (out_free) begin
                    n_out_valid  = 1'b1;
                    n_out_status = r_status;
                    n_out_found  = r_found;
                    n_out_total  = TOTAL_W'(r_count);
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_cmd        <= n_cmd;
        r_key        <= n_key;
        r_val        <= n_val;
        r_idx        <= n_idx;
        r_status     <= n_status;
        r_found      <= n_found;
        r_out_status <= n_out_status;
        r_out_found  <= n_out_found;
        r_out_total  <= n_out_total;
    end

    assign o_in_ready    = (r_state == S_IDLE);
    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_found_value = r_out_found;
    assign o_entry_total = r_out_total;

endmodule
`default_nettype wire

### rtl/linear_key_value_table.sv
// Fixed-capacity key/value table, entries packed in insertion order, exact-match
// lookup by a linear scan. One command at a time: o_in_ready is high only while
// idle. A command reads one slot at a time, a read state then a compare state,
// through a store with one read and one write port, registered read data and
// one shared key comparator; remove then moves each later entry down through a
// shift read state and a shift write state. The longest commands are a miss on
// a full table and removal of the first of a full table's entries. Full-table
// inserts, unused codes and commands on an empty table go straight from idle to
// the done state without a store read. A finished result sits in an output
// register, so the next beat is taken while it waits; that next command then
// holds in its final cycle until the waiting result is taken.
// Store contents need no clearing after reset.
`default_nettype none
module linear_key_value_table #(
    parameter int CAPACITY = lkvt_pkg::LKVT_CAPACITY
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_ready,
    input  wire logic [lkvt_pkg::CMD_W-1:0]     i_command,
    input  wire logic [lkvt_pkg::KEY_W-1:0]     i_key,
    input  wire logic [lkvt_pkg::VALUE_W-1:0]   i_new_value,
    output logic                               o_out_valid,
    input  wire logic                          i_out_ready,
    output logic      [lkvt_pkg::STATUS_W-1:0]  o_status,
    output logic      [lkvt_pkg::VALUE_W-1:0]   o_found_value,
    output logic      [lkvt_pkg::TOTAL_W-1:0]   o_entry_total
);
    import lkvt_pkg::*;

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic               mem_we;
    logic [IDX_W-1:0]   mem_waddr;
    logic [KEY_W-1:0]   mem_wkey;
    logic [VALUE_W-1:0] mem_wval;
    logic [IDX_W-1:0]   mem_raddr;
    logic [KEY_W-1:0]   mem_rkey;
    logic [VALUE_W-1:0] mem_rval;

    lkvt_seq #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W),
        .CNT_W    (CNT_W)
    ) u_seq (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_valid    (i_in_valid),
        .o_in_ready    (o_in_ready),
        .i_command     (i_command),
        .i_key         (i_key),
        .i_new_value   (i_new_value),
        .o_out_valid   (o_out_valid),
        .i_out_ready   (i_out_ready),
        .o_status      (o_status),
        .o_found_value (o_found_value),
        .o_entry_total (o_entry_total),
        .o_we          (mem_we),
        .o_waddr       (mem_waddr),
        .o_wkey        (mem_wkey),
        .o_wval        (mem_wval),
        .o_raddr       (mem_raddr),
        .i_rkey        (mem_rkey),
        .i_rval        (mem_rval)
    );

    lkvt_store #(
        .CAPACITY (CAPACITY),
        .IDX_W    (IDX_W)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wkey  (mem_wkey),
        .i_wval  (mem_wval),
        .i_raddr (mem_raddr),
        .o_rkey  (mem_rkey),
        .o_rval  (mem_rval)
    );

endmodule
`default_nettype wire

### rtl/lkvt_checker.sv
`default_nettype none
module lkvt_checker #(
    parameter int CAPACITY = lkvt_pkg::LKVT_CAPACITY
) (
    input wire logic                         i_clk,
    input wire logic                         i_rst_n,
    input wire logic                         i_in_valid,
    input wire logic                         o_in_ready,
    input wire logic                         o_out_valid,
    input wire logic                         i_out_ready,
    input wire logic [lkvt_pkg::STATUS_W-1:0] o_status,
    input wire logic [lkvt_pkg::VALUE_W-1:0]  o_found_value,
    input wire logic [lkvt_pkg::TOTAL_W-1:0]  o_entry_total
);
    import lkvt_pkg::*;

    // one command in flight: no beat taken on the cycle after an accepted one
    a_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input beat taken while busy");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_status)
            && $stable(o_found_value) && $stable(o_entry_total)))
        else $error("result beat changed while stalled");

    a_fail_no_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status != ST_OK) |-> (o_found_value == '0))
        else $error("value reported on a failed command");

    a_full_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_FULL) |-> (o_entry_total == TOTAL_W'(CAPACITY)))
        else $error("table full reported below capacity");

    a_dup_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_status == ST_DUP) |-> (o_entry_total != '0))
        else $error("duplicate reported on an empty table");

endmodule

bind linear_key_value_table lkvt_checker #(.CAPACITY(CAPACITY)) u_lkvt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_in_valid),
    .o_in_ready    (o_in_ready),
    .o_out_valid   (o_out_valid),
    .i_out_ready   (i_out_ready),
    .o_status      (o_status),
    .o_found_value (o_found_value),
    .o_entry_total (o_entry_total)
);
`default_nettype wire
